[hw/rtl/assert_macros.svh]
// assertion helpers used by cycle_letter_consistency_prune
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is held
`define CLCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define CLCP_NEVER(name, cond, msg) \
  `CLCP_ASSERT(name, !(cond), msg)

`endif

[hw/rtl/clcp_pkg.sv]
package clcp_pkg;

  // letter alphabet and payload widths
  localparam int unsigned ALPHABET       = 26;
  localparam int unsigned MASK_W         = 26;
  localparam int unsigned LETTER_W       = 5;
  localparam int unsigned LAYER_W        = 3;
  localparam int unsigned OPCODE_W       = 2;
  localparam int unsigned A_W            = $clog2(ALPHABET);
  localparam int unsigned MAX_LAYERS_DEF = 8;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_NODE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_EDGE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN  = 2'd2;

  // configuration registers
  localparam int unsigned CFG_LEN_W     = 4;
  localparam logic [CFG_LEN_W-1:0] LENGTH_RST = 4'd4;
  localparam logic REG_LENGTH = 1'b0;

  // control of the shared step unit
  typedef struct packed {
    logic beat;
    logic rev;
    logic clear;
  } step_ctrl_t;

endpackage

[hw/rtl/clcp_if.sv]
interface clcp_in_if;
  logic                               valid;
  logic                               ready;
  logic [clcp_pkg::OPCODE_W-1:0]      opcode;
  logic [clcp_pkg::LAYER_W-1:0]       layer;
  logic [clcp_pkg::LETTER_W-1:0]      letter;
  logic [clcp_pkg::MASK_W-1:0]        mask_a;
  logic [clcp_pkg::MASK_W-1:0]        mask_b;

  modport source (output valid, opcode, layer, letter, mask_a, mask_b, input ready);
  modport sink (input valid, opcode, layer, letter, mask_a, mask_b, output ready);
endinterface

interface clcp_out_if;
  logic                               valid;
  logic                               ready;
  logic [clcp_pkg::LAYER_W-1:0]       out_layer;
  logic [clcp_pkg::MASK_W-1:0]        remove_mask;
  logic                               last;

  modport source (output valid, out_layer, remove_mask, last, input ready);
  modport sink (input valid, out_layer, remove_mask, last, output ready);
endinterface

[hw/rtl/clcp_ram.sv]
module clcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/clcp_step.sv]
module clcp_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  clcp_pkg::step_ctrl_t            ctrl_i,
  input  logic [clcp_pkg::A_W-1:0]        j_i,
  input  logic [clcp_pkg::MASK_W-1:0]     row_i,
  input  logic [clcp_pkg::MASK_W-1:0]     cur_i,
  output logic [clcp_pkg::MASK_W-1:0]     acc_o
);

  logic [clcp_pkg::MASK_W-1:0] acc_q, acc_d;

  // fold one edge row into the reach set
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.beat) begin
      if (ctrl_i.rev) begin
        // reverse: node j is reached when its row hits the current set
        acc_d[j_i] = acc_q[j_i] | (|(row_i & cur_i));
      end else if (cur_i[j_i]) begin
        // forward: every target of a current node is reached
        acc_d = acc_q | row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_d;

endmodule

[hw/rtl/cycle_letter_consistency_prune.sv]
// loads (node mask, edge row) are accepted only while idle; a run emits one beat per layer
// a run walks each layer-0 node in the mask forward and back through the edge rows, skips
// other roots, then sends n output beats; the walk is paced by the single edge ram read port,
// one row per cycle; no input is taken during a run
// reset clears the edge store at once (valid bit per row); cycle_length resets to 4
// node masks hold no reset value and must be loaded before a run
`include "assert_macros.svh"

module cycle_letter_consistency_prune #(
  parameter int unsigned MAX_LAYERS = clcp_pkg::MAX_LAYERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clcp_in_if.sink           in_i,
  clcp_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned A     = clcp_pkg::ALPHABET;
  localparam int unsigned AW    = clcp_pkg::A_W;
  localparam int unsigned MW    = clcp_pkg::MASK_W;
  localparam int unsigned LW    = $clog2(MAX_LAYERS);
  localparam int unsigned NW    = LW + 1;
  localparam int unsigned DEPTH = MAX_LAYERS * A;
  localparam int unsigned DW    = $clog2(DEPTH);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_ROOT    = 8'b0000_0010,
    ST_FWD_RD  = 8'b0000_0100,
    ST_FWD_END = 8'b0000_1000,
    ST_REV_RD  = 8'b0001_0000,
    ST_REV_END = 8'b0010_0000,
    ST_COMB    = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [clcp_pkg::CFG_LEN_W-1:0] length_q;
  logic [MW-1:0] node_q  [MAX_LAYERS];
  logic [MW-1:0] fwd_q   [MAX_LAYERS];
  logic [MW-1:0] rev_q   [MAX_LAYERS];
  logic [MW-1:0] oncyc_q [MAX_LAYERS];
  logic [DEPTH-1:0] edge_vld_q;

  logic [AW-1:0] root_q, j_q, rd_j_q;
  logic [LW-1:0] lay_q, emit_q;
  logic [MW-1:0] cur_q;
  logic          rd_v_q;
  logic [DW-1:0] rd_addr_q;

  logic          out_v_q, out_last_q;
  logic [clcp_pkg::LAYER_W-1:0] out_layer_q;
  logic [MW-1:0] out_mask_q;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == clcp_pkg::REG_LENGTH);
  assign prdata = (paddr[2] == clcp_pkg::REG_LENGTH) ? 32'(length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= clcp_pkg::LENGTH_RST;
    end else if (cfg_wr) begin
      length_q <= pwdata[clcp_pkg::CFG_LEN_W-1:0];
    end
  end

  // effective cycle length, saturated to 2..MAX_LAYERS
  logic [NW-1:0] eff_n;
  logic [LW-1:0] n_last;
  always_comb begin
    if (length_q < 2) begin
      eff_n = NW'(2);
    end else if (32'(length_q) > MAX_LAYERS) begin
      eff_n = NW'(MAX_LAYERS);
    end else begin
      eff_n = NW'(length_q);
    end
  end
  assign n_last = LW'(eff_n - NW'(1));

  // input beat decode
  logic          in_acc, ld_ok, node_we, edge_we;
  logic [LW-1:0] ld_lay;
  logic [DW-1:0] edge_waddr;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ld_ok      = 32'(in_i.layer) < MAX_LAYERS;
  assign ld_lay     = LW'(in_i.layer);
  assign node_we    = in_acc && (in_i.opcode == clcp_pkg::OP_NODE) && ld_ok;
  assign edge_we    = in_acc && (in_i.opcode == clcp_pkg::OP_EDGE) && ld_ok
                      && (32'(in_i.letter) < A);
  assign edge_waddr = DW'(32'(ld_lay) * A + 32'(in_i.letter));

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_q[ld_lay] <= in_i.mask_a & in_i.mask_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_vld_q <= '0;
    end else if (edge_we) begin
      edge_vld_q[edge_waddr] <= 1'b1;
    end
  end

  // edge row store
  logic          rd_en;
  logic [DW-1:0] rd_addr;
  logic [MW-1:0] rd_data, row;
  assign rd_en   = (state_q == ST_FWD_RD) || (state_q == ST_REV_RD);
  assign rd_addr = DW'(32'(lay_q) * A + 32'(j_q));

  clcp_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (in_i.mask_a),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign row = edge_vld_q[rd_addr_q] ? rd_data : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_j_q    <= j_q;
    rd_addr_q <= rd_addr;
  end

  // shared reach step unit
  clcp_pkg::step_ctrl_t step_ctrl;
  logic [MW-1:0] step_acc;
  assign step_ctrl.beat  = rd_v_q;
  assign step_ctrl.rev   = (state_q == ST_REV_RD) || (state_q == ST_REV_END);
  assign step_ctrl.clear = (state_q == ST_FWD_END) || (state_q == ST_REV_END)
                           || (state_q == ST_ROOT);

  clcp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (step_ctrl),
    .j_i    (rd_j_q),
    .row_i  (row),
    .cur_i  (cur_q),
    .acc_o  (step_acc)
  );

  // single node mask read port
  logic [LW-1:0] nm_idx, fwd_to;
  logic [MW-1:0] nm_rd, root_bit, step_res;
  assign fwd_to = LW'(lay_q + LW'(1));
  always_comb begin
    case (state_q)
      ST_FWD_END: nm_idx = fwd_to;
      ST_REV_END: nm_idx = lay_q;
      ST_EMIT:    nm_idx = emit_q;
      default:    nm_idx = '0;
    endcase
  end
  assign nm_rd    = node_q[nm_idx];
  assign root_bit = MW'(1) << root_q;
  assign step_res = step_acc & nm_rd;

  // output register handshake
  logic emit_ld, emit_last;
  assign emit_ld   = (state_q == ST_EMIT) && (!out_v_q || out_o.ready);
  assign emit_last = (emit_q == n_last);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == clcp_pkg::OP_RUN)) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (nm_rd[root_q]) begin
          state_d = ST_FWD_RD;
        end else if (root_q == AW'(A - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_FWD_RD: begin
        if (j_q == AW'(A - 1)) state_d = ST_FWD_END;
      end
      ST_FWD_END: begin
        state_d = (fwd_to == n_last) ? ST_REV_RD : ST_FWD_RD;
      end
      ST_REV_RD: begin
        if (j_q == AW'(A - 1)) state_d = ST_REV_END;
      end
      ST_REV_END: begin
        state_d = (lay_q == LW'(1)) ? ST_COMB : ST_REV_RD;
      end
      ST_COMB: begin
        state_d = (root_q == AW'(A - 1)) ? ST_EMIT : ST_ROOT;
      end
      ST_EMIT: begin
        if (emit_ld && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      root_q  <= '0;
      j_q     <= '0;
      lay_q   <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          root_q <= '0;
          emit_q <= '0;
        end
        ST_ROOT: begin
          j_q   <= '0;
          lay_q <= '0;
          if (!nm_rd[root_q]) root_q <= AW'(root_q + AW'(1));
        end
        ST_FWD_RD, ST_REV_RD: begin
          j_q <= (j_q == AW'(A - 1)) ? '0 : AW'(j_q + AW'(1));
        end
        ST_FWD_END: begin
          lay_q <= (fwd_to == n_last) ? n_last : fwd_to;
        end
        ST_REV_END: begin
          lay_q <= LW'(lay_q - LW'(1));
        end
        ST_COMB: begin
          root_q <= AW'(root_q + AW'(1));
        end
        ST_EMIT: begin
          if (emit_ld) emit_q <= LW'(emit_q + LW'(1));
        end
        default: begin
          root_q <= '0;
        end
      endcase
    end
  end

  // reach sets of the current root
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ROOT: begin
        cur_q <= root_bit;
        for (int i = 0; i < MAX_LAYERS; i++) begin
          fwd_q[i] <= '0;
          rev_q[i] <= '0;
        end
        fwd_q[0] <= root_bit;
        rev_q[0] <= root_bit;
      end
      ST_FWD_END: begin
        fwd_q[fwd_to] <= step_res;
        cur_q         <= (fwd_to == n_last) ? root_bit : step_res;
      end
      ST_REV_END: begin
        rev_q[lay_q] <= step_res;
        cur_q        <= step_res;
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  // on-cycle marks, cleared at run start
  logic closes;
  assign closes = |(fwd_q[1] & rev_q[1]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LAYERS; i++) oncyc_q[i] <= '0;
    end else if (state_q == ST_IDLE && state_d == ST_ROOT) begin
      for (int i = 0; i < MAX_LAYERS; i++) oncyc_q[i] <= '0;
    end else if (state_q == ST_COMB && closes) begin
      for (int i = 0; i < MAX_LAYERS; i++) oncyc_q[i] <= oncyc_q[i] | (fwd_q[i] & rev_q[i]);
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit_ld) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ld) begin
      out_layer_q <= clcp_pkg::LAYER_W'(emit_q);
      out_mask_q  <= nm_rd & ~oncyc_q[emit_q];
      out_last_q  <= emit_last;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.out_layer   = out_layer_q;
  assign out_o.remove_mask = out_mask_q;
  assign out_o.last        = out_last_q;

  // checks
  `CLCP_ASSERT(a_last_beat_ends_run, emit_ld && emit_last |=> state_q == ST_IDLE, "run did not end after last beat")
  `CLCP_NEVER(a_no_read_beat_idle, rd_v_q && (state_q == ST_IDLE), "edge read beat outside a walk")
  `CLCP_ASSERT(a_emit_in_range, (state_q == ST_EMIT) |-> (NW'(emit_q) < eff_n), "emit layer beyond cycle length")

endmodule

[bench/cycle_letter_consistency_prune_tb.sv]
`timescale 1ns / 100ps

module cycle_letter_consistency_prune_tb;

  localparam int unsigned OPCODE_W       = clcp_pkg::OPCODE_W;
  localparam int unsigned LAYER_W        = clcp_pkg::LAYER_W;
  localparam int unsigned LETTER_W       = clcp_pkg::LETTER_W;
  localparam int unsigned MASK_W         = clcp_pkg::MASK_W;
  localparam int unsigned CFG_LEN_W      = clcp_pkg::CFG_LEN_W;
  localparam int unsigned ALPHABET       = clcp_pkg::ALPHABET;
  localparam int unsigned MAX_LAYERS_DEF = clcp_pkg::MAX_LAYERS_DEF;
  localparam int unsigned REG_LEN_IDX    = 32'(clcp_pkg::REG_LENGTH);

  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned REG_UNUSED     = 1;
  localparam int unsigned RANDOM_ITEMS   = 160;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT    = 12_000_000;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [LAYER_W-1:0]  layer;
    logic [LETTER_W-1:0] letter;
    logic [MASK_W-1:0]   mask_a;
    logic [MASK_W-1:0]   mask_b;
  } load_item_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [MASK_W-1:0]  remove_mask;
    logic               last;
  } removal_t;

  // mirror of the letter graph and the removal masks each run should report
  class cycle_prune_checker;
    logic [MASK_W-1:0]    node_mask [MAX_LAYERS_DEF];
    logic [MASK_W-1:0]    edge_row [MAX_LAYERS_DEF][ALPHABET];
    logic [CFG_LEN_W-1:0] reg_length;
    removal_t             removal_q[$];
    int unsigned          errors;

    function new();
      foreach (node_mask[i]) node_mask[i] = '0;
      foreach (edge_row[i, j]) edge_row[i][j] = '0;
      reg_length = clcp_pkg::LENGTH_RST;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endfunction

    // layers a run walks: register saturated to the legal range
    function int unsigned layer_count();
      if (reg_length < 2) return 2;
      if (reg_length > MAX_LAYERS_DEF) return MAX_LAYERS_DEF;
      return 32'(reg_length);
    endfunction

    function void note_config(int unsigned idx, logic [31:0] value);
      if (idx == REG_LEN_IDX) begin
        reg_length = value[CFG_LEN_W-1:0];
      end
    endfunction

    function void check_length(logic [31:0] rd);
      if (rd[CFG_LEN_W-1:0] !== reg_length) begin
        report($sformatf("cycle_length read: expected %0d, got %0d",
                         reg_length, rd[CFG_LEN_W-1:0]));
      end
    endfunction

    function void predict_run();
      logic [MASK_W-1:0] on_cycle [MAX_LAYERS_DEF];
      logic [MASK_W-1:0] fwd [MAX_LAYERS_DEF];
      logic [MASK_W-1:0] bwd [MAX_LAYERS_DEF];
      logic [MASK_W-1:0] cur, nxt;
      int unsigned n, t;
      n = layer_count();
      foreach (on_cycle[i]) on_cycle[i] = '0;
      for (int root = 0; root < ALPHABET; root++) begin
        if (!node_mask[0][root]) continue;
        foreach (fwd[i]) begin
          fwd[i] = '0;
          bwd[i] = '0;
        end
        // forward reach along edges
        cur = '0;
        cur[root] = 1'b1;
        fwd[0] = cur;
        for (int s = 1; s < n; s++) begin
          nxt = '0;
          for (int j = 0; j < ALPHABET; j++) begin
            if (cur[j]) nxt |= edge_row[s-1][j];
          end
          fwd[s] = nxt & node_mask[s];
          cur = fwd[s];
        end
        // backward reach against edges, closing through the last layer
        cur = '0;
        cur[root] = 1'b1;
        bwd[0] = cur;
        for (int s = 0; s + 1 < n; s++) begin
          t = n - 1 - s;
          nxt = '0;
          for (int j = 0; j < ALPHABET; j++) begin
            if ((edge_row[t][j] & cur) != '0) nxt[j] = 1'b1;
          end
          bwd[t] = nxt & node_mask[t];
          cur = bwd[t];
        end
        if ((fwd[1] & bwd[1]) != '0) begin
          for (int i = 0; i < n; i++) on_cycle[i] |= fwd[i] & bwd[i];
        end
      end
      for (int i = 0; i < n; i++) begin
        removal_q.insert(removal_q.size(),
                         removal_t'{LAYER_W'(i), node_mask[i] & ~on_cycle[i], i == n - 1});
      end
    endfunction

    function void note_item(load_item_t it);
      case (it.opcode)
        clcp_pkg::OP_NODE: node_mask[it.layer] = it.mask_a & it.mask_b;
        clcp_pkg::OP_EDGE: begin
          if (it.letter < ALPHABET) edge_row[it.layer][it.letter] = it.mask_a;
        end
        clcp_pkg::OP_RUN:  predict_run();
        default: ;
      endcase
    endfunction

    function void check_beat(removal_t got);
      removal_t want;
      if (removal_q.size() == 0) begin
        report($sformatf("result with nothing expected: layer %0d mask %h last %b",
                         got.layer, got.remove_mask, got.last));
        return;
      end
      want = removal_q.pop_front();
      if (got.layer !== want.layer || got.remove_mask !== want.remove_mask ||
          got.last !== want.last) begin
        report($sformatf("expected layer %0d mask %h last %b, got layer %0d mask %h last %b",
                         want.layer, want.remove_mask, want.last,
                         got.layer, got.remove_mask, got.last));
      end
    endfunction

    function void close_out();
      removal_t want;
      while (removal_q.size() != 0) begin
        want = removal_q.pop_front();
        report($sformatf("missing result: layer %0d mask %h last %b",
                         want.layer, want.remove_mask, want.last));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  clcp_in_if  in_if ();
  clcp_out_if out_if ();

  cycle_prune_checker sb;
  int unsigned        item_count;
  int unsigned        cycle_count;
  bit                 burst;

  cycle_letter_consistency_prune DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[cycle_letter_consistency_prune] ERROR");
    $finish;
  end

  // result side backpressure: open stretches, long stalls, choppy ready
  initial begin
    int unsigned mode;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(9, 0);
      if (mode < 3) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(150, 20)) @(posedge clk_i);
      end else if (mode < 4) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(60, 15)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(40, 10)) begin
          out_if.ready <= ($urandom_range(3, 0) != 0);
          @(posedge clk_i);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_beat(removal_t'{out_if.out_layer, out_if.remove_mask, out_if.last});
    end
  end

  function automatic load_item_t pack_item(logic [OPCODE_W-1:0] op, int unsigned layer,
                                           int unsigned letter, logic [MASK_W-1:0] a,
                                           logic [MASK_W-1:0] b);
    load_item_t it;
    it.opcode = op;
    it.layer  = LAYER_W'(layer);
    it.letter = LETTER_W'(letter);
    it.mask_a = a;
    it.mask_b = b;
    return it;
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    return MASK_W'($urandom());
  endfunction

  // small random letter set that a well-formed graph lives in
  function automatic logic [MASK_W-1:0] pick_pool();
    logic [MASK_W-1:0] pool;
    int unsigned k;
    pool = '0;
    k = $urandom_range(6, 2);
    while ($countones(pool) < k) pool[$urandom_range(ALPHABET - 1, 0)] = 1'b1;
    return pool;
  endfunction

  function automatic int unsigned pick_letter(logic [MASK_W-1:0] pool);
    int unsigned l;
    do l = $urandom_range(ALPHABET - 1, 0); while (!pool[l]);
    return l;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // one input beat, with a random gap in front
  task automatic send_item(load_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.opcode <= it.opcode;
    in_if.layer  <= it.layer;
    in_if.letter <= it.letter;
    in_if.mask_a <= it.mask_a;
    in_if.mask_b <= it.mask_b;
    in_if.valid  <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    if (!(it.opcode == OP_NONE || (it.opcode == clcp_pkg::OP_EDGE && it.letter >= ALPHABET)))
    begin
      item_count++;
    end
  endtask

  // hold input until every pending result has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.removal_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(int unsigned idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.note_config(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apb_read(int unsigned idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // register write on an idle block, then read cycle_length back
  task automatic write_register(int unsigned idx, logic [31:0] value);
    logic [31:0] rd;
    drain();
    apb_write(idx, value);
    apb_read(REG_LEN_IDX, rd);
    sb.check_length(rd);
  endtask

  // node loads and edge rows inside one letter set, then a run
  task automatic send_episode();
    logic [MASK_W-1:0] pool;
    int unsigned n;
    int unsigned cut_layer;
    bit broken;
    pool = pick_pool();
    n = sb.layer_count();
    broken = ($urandom_range(6, 0) == 0);
    cut_layer = $urandom_range(n - 1, 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) < 7) begin
        send_item(pack_item(clcp_pkg::OP_NODE, i, $urandom_range(31, 0), rand_mask() | pool,
                            ($urandom_range(3, 0) == 0) ? (pool & rand_mask()) : pool));
      end
    end
    for (int i = 0; i < n; i++) begin
      if (broken && i == cut_layer) continue;
      repeat ($urandom_range(2, 1)) begin
        send_item(pack_item(clcp_pkg::OP_EDGE, i, pick_letter(pool),
                            pool & (rand_mask() | rand_mask()), rand_mask()));
      end
    end
    if ($urandom_range(4, 0) == 0) drain();
    send_item(pack_item(clcp_pkg::OP_RUN, $urandom_range(7, 0), $urandom_range(31, 0),
                        rand_mask(), rand_mask()));
  endtask

  initial begin
    logic [31:0] rd;
    logic [31:0] len_val;
    int unsigned phase;
    int unsigned phase_end;
    sb = new();
    burst = 1'b0;
    item_count = 0;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= '0;
    in_if.layer  <= '0;
    in_if.letter <= '0;
    in_if.mask_a <= '0;
    in_if.mask_b <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // register value out of reset
    apb_read(REG_LEN_IDX, rd);
    sb.check_length(rd);

    // every layer full, run with an empty edge store and all 26 roots
    for (int i = 0; i < MAX_LAYERS_DEF; i++) begin
      send_item(pack_item(clcp_pkg::OP_NODE, i, 0, '1, '1));
    end
    send_item(pack_item(clcp_pkg::OP_RUN, 0, 0, '0, '0));

    // four-letter ring through four layers
    send_item(pack_item(clcp_pkg::OP_EDGE, 0, 0, 26'b10, '0));
    send_item(pack_item(clcp_pkg::OP_EDGE, 1, 1, 26'b100, '0));
    send_item(pack_item(clcp_pkg::OP_EDGE, 2, 2, 26'b1000, '0));
    send_item(pack_item(clcp_pkg::OP_EDGE, 3, 3, 26'b1, '0));
    // letters past the alphabet and the unused opcode change nothing
    send_item(pack_item(clcp_pkg::OP_EDGE, 0, 31, '1, '1));
    send_item(pack_item(clcp_pkg::OP_EDGE, 7, 26, '1, '0));
    send_item(pack_item(OP_NONE, 7, 31, '1, '1));
    send_item(pack_item(clcp_pkg::OP_RUN, 7, 31, '1, '1));

    // an empty layer breaks every cycle
    send_item(pack_item(clcp_pkg::OP_NODE, 2, 0, '1, '0));
    send_item(pack_item(clcp_pkg::OP_RUN, 0, 0, '0, '0));

    // unknown register index leaves cycle_length alone
    write_register(REG_UNUSED, 32'h0000_0002);

    // shortest cycle: two layers, letter 5 both ways
    write_register(REG_LEN_IDX, 32'd2);
    send_item(pack_item(clcp_pkg::OP_EDGE, 0, 5, 26'b10_0000, '0));
    send_item(pack_item(clcp_pkg::OP_EDGE, 1, 5, 26'b10_0000, '0));
    send_item(pack_item(clcp_pkg::OP_RUN, 0, 0, '0, '0));

    // longest cycle
    write_register(REG_LEN_IDX, 32'd8);
    send_item(pack_item(clcp_pkg::OP_NODE, 2, 0, '1, '1));
    send_item(pack_item(clcp_pkg::OP_RUN, 0, 0, '0, '0));

    // random phases, each under its own cycle_length
    item_count = 0;
    phase = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (phase == 0) begin
        len_val = 32'd0;
      end else if (phase == 1) begin
        len_val = 32'hFFFF_FFFF;
      end else if ($urandom_range(4, 0) == 0) begin
        len_val = $urandom();
      end else begin
        len_val = $urandom_range(8, 2);
      end
      write_register(REG_LEN_IDX, len_val);
      burst = ($urandom_range(3, 0) == 0);
      phase_end = item_count + $urandom_range(30, 15);
      while (item_count < phase_end && item_count < RANDOM_ITEMS) begin
        if ($urandom_range(99, 0) < 15) begin
          send_item(pack_item(OPCODE_W'($urandom_range(3, 0)), $urandom_range(7, 0),
                              $urandom_range(31, 0), rand_mask(), rand_mask()));
        end else begin
          send_episode();
        end
      end
      phase++;
    end

    drain();
    repeat (END_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("[cycle_letter_consistency_prune] OK");
    end else begin
      $display("[cycle_letter_consistency_prune] ERROR");
    end
    $finish;
  end

endmodule

[cycle_letter_consistency_prune.f]
+incdir+hw/rtl
hw/rtl/clcp_pkg.sv
hw/rtl/clcp_if.sv
hw/rtl/clcp_ram.sv
hw/rtl/clcp_step.sv
hw/rtl/cycle_letter_consistency_prune.sv
bench/cycle_letter_consistency_prune_tb.sv
